// ===== sv/aik_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aik_pkg: shared constants for the arm inverse kinematics pipeline
// Register codes, CORDIC angle table and datapath widths.
// ----------------------------------------------------------------------------
package aik_pkg;

  // Configuration register codes (word index on the APB port)
  typedef enum logic [1:0] {
    REG_UPPER_ARM  = 2'd0,
    REG_FOREARM    = 2'd1,
    REG_OFFSET     = 2'd2,
    REG_FALLBACK_X = 2'd3
  } reg_idx_t;

  // Angle accumulator: radians * 2^32, signed
  localparam int ANG_W        = 36;
  // Operand width before normalization
  localparam int NORM_W       = 64;
  // CORDIC x/y width after normalization into [2^40, 2^41)
  localparam int CORDIC_W     = 44;
  localparam int NORM_STEPS   = 6;
  localparam int CORDIC_STEPS = 32;

  localparam logic signed [ANG_W-1:0] PI_Q32 = 36'sd13493037704;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175347, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512,
    32'd256,        32'd128,        32'd64,         32'd32,
    32'd16,         32'd8,          32'd4,          32'd2
  };

endpackage
`default_nettype wire

// ===== sv/arm_inverse_kinematics_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arm_inverse_kinematics_top: pan/shoulder/elbow solver for an elbow arm
// Reach check with fallback target, elbow cosine by long division, two
// square roots and five CORDIC atan2 units, all fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   -----------------------   ---------------------------------------
//  target    start in, busy out        target_x/y/z, current_pan
//  angles    done out (one cycle)      pan/shoulder/elbow angle, flags
//  config    APB psel/penable/pwrite   paddr, pwdata, prdata, pready
//
//  One item per cycle, every cycle; busy stays low. Each item passes the
//  chain reach check, root of the planar distance, 30-step division,
//  root of 1-D^2 and the 40-stage CORDIC.
//  Reset (synchronous) clears the valid bits and loads the register defaults.
//  The receiver cannot stall: each result shows on done for one cycle.
//
module arm_inverse_kinematics_top import aik_pkg::*; #(
  parameter int COORD_WIDTH     = 16,
  parameter int ANGLE_FRAC_BITS = 15
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] target_x,
  input  wire logic signed [COORD_WIDTH-1:0] target_y,
  input  wire logic signed [COORD_WIDTH-1:0] target_z,
  input  wire logic signed [17:0]            current_pan,
  output logic                               done,
  output logic [17:0]                        pan_angle,
  output logic [18:0]                        shoulder_angle,
  output logic [17:0]                        elbow_angle,
  output logic                               out_of_reach,
  output logic                               pan_held,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [3:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int CW   = COORD_WIDTH;
  localparam int XW   = (CW > 16) ? CW : 16;   // selected coordinate width
  localparam int SW   = 2 * XW - 1;            // one square, unsigned
  localparam int SUMW = SW + 2;
  localparam int NW   = SW + 3;                // elbow numerator, signed
  localparam int XYW  = SW + 1;
  localparam int VRW  = XYW + 16;
  localparam int RW   = (VRW + 1) / 2;
  localparam int DENW = 29;
  localparam int QB   = 30;
  localparam int SVW  = 61;
  localparam int SRW  = (SVW + 1) / 2;
  localparam int TW   = ANG_W + 1;
  localparam int SH   = 32 - ANGLE_FRAC_BITS;
  localparam logic [TW-1:0] HALF = TW'(1) << (SH - 1);
  localparam logic signed [31:0] ONE_Q30 = 32'sd1 << 30;

  typedef struct packed {
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [XW-1:0] zs;
    logic signed [17:0]   cur;
    logic                 oor;
    logic                 held;
  } item_t;

  typedef struct packed {
    logic signed [NW-1:0] num;
    item_t                it;
  } rtag_t;

  typedef struct packed {
    logic [DENW-1:0]    rem;
    logic [QB-1:0]      q;
    logic               neg;
    logic               special;
    logic signed [31:0] spv;
    logic [RW-1:0]      r;
    item_t              it;
  } div_t;

  typedef struct packed {
    logic signed [31:0] dq;
    logic [RW-1:0]      r;
    item_t              it;
  } stag_t;

  typedef struct packed {
    logic signed [17:0] cur;
    logic               oor;
    logic               held;
  } ctag_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [13:0]        upper_arm_length;
  logic [13:0]        forearm_length;
  logic signed [13:0] shoulder_offset;
  logic signed [15:0] fallback_x;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_arm_length <= 14'd8960;
      forearm_length   <= 14'd6400;
      shoulder_offset  <= '0;
      fallback_x       <= 16'sd15360;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_UPPER_ARM:  upper_arm_length <= pwdata[13:0];
        REG_FOREARM:    forearm_length   <= pwdata[13:0];
        REG_OFFSET:     shoulder_offset  <= pwdata[13:0];
        REG_FALLBACK_X: fallback_x       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_UPPER_ARM:  prdata = {18'b0, upper_arm_length};
      REG_FOREARM:    prdata = {18'b0, forearm_length};
      REG_OFFSET:     prdata = {18'b0, shoulder_offset};
      REG_FALLBACK_X: prdata = {16'b0, fallback_x};
      default:        prdata = '0;
    endcase
  end

  // Register-only products; refresh every cycle
  logic [29:0]     reach2;
  logic [26:0]     dd;
  logic [27:0]     a22, a33;
  logic [DENW-1:0] den;
  logic [13:0]     abs_d;
  logic [14:0]     reach;

  always_comb begin
    abs_d = shoulder_offset[13] ? 14'(-shoulder_offset) : shoulder_offset;
    reach = {1'b0, upper_arm_length} + {1'b0, forearm_length};
  end

  always_ff @(posedge clk) begin
    reach2 <= {15'b0, reach} * {15'b0, reach};
    dd     <= 27'({14'b0, abs_d} * {14'b0, abs_d});
    a22    <= {14'b0, upper_arm_length} * {14'b0, upper_arm_length};
    a33    <= {14'b0, forearm_length} * {14'b0, forearm_length};
    den    <= {{14'b0, upper_arm_length} * {14'b0, forearm_length}, 1'b0};
  end

  // --------------------------------------------------------------------------
  // P1..P4: capture, squares, reach check, numerator and planar distance
  // --------------------------------------------------------------------------
  logic in_acc;
  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  logic v1, v2, v3, v4;
  logic signed [CW-1:0] x1, y1, z1, x2, y2, z2;
  logic signed [17:0]   cur1, cur2;
  logic [CW-1:0]        ax1, ay1, az1;
  logic [15:0]          afb;
  logic [SW-1:0]        ux2, uy2, uz2, fb2;
  logic [SUMW-1:0]      sum2;
  logic                 far2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_acc;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    x1   <= target_x;
    y1   <= target_y;
    z1   <= target_z;
    cur1 <= current_pan;
  end

  always_comb begin
    ax1 = x1[CW-1] ? CW'(-x1) : x1;
    ay1 = y1[CW-1] ? CW'(-y1) : y1;
    az1 = z1[CW-1] ? CW'(-z1) : z1;
    afb = fallback_x[15] ? 16'(-fallback_x) : fallback_x;
  end

  always_ff @(posedge clk) begin
    x2   <= x1;
    y2   <= y1;
    z2   <= z1;
    cur2 <= cur1;
    ux2  <= SW'({{CW{1'b0}}, ax1} * {{CW{1'b0}}, ax1});
    uy2  <= SW'({{CW{1'b0}}, ay1} * {{CW{1'b0}}, ay1});
    uz2  <= SW'({{CW{1'b0}}, az1} * {{CW{1'b0}}, az1});
    fb2  <= SW'({16'b0, afb} * {16'b0, afb});
  end

  always_comb begin
    sum2 = SUMW'(ux2) + SUMW'(uy2) + SUMW'(uz2);
    far2 = sum2 > SUMW'(reach2);
  end

  // Swap in the fallback target when out of reach
  item_t          it3, it4;
  logic [SW-1:0]  xx3, yy3, zz3;

  always_ff @(posedge clk) begin
    it3.cur  <= cur2;
    it3.oor  <= far2;
    it3.held <= 1'b0;
    if (far2) begin
      it3.xs <= XW'(fallback_x);
      it3.ys <= '0;
      it3.zs <= '0;
      xx3    <= fb2;
      yy3    <= '0;
      zz3    <= '0;
    end else begin
      it3.xs <= XW'(x2);
      it3.ys <= XW'(y2);
      it3.zs <= XW'(z2);
      xx3    <= ux2;
      yy3    <= uy2;
      zz3    <= uz2;
    end
  end

  logic [NW-1:0]  num_sum;
  logic [XYW:0]   xy_raw;
  logic [XYW-1:0] xyv4;
  logic [NW-1:0]  num4;

  always_comb begin
    num_sum = NW'(xx3) + NW'(yy3) + NW'(zz3) - NW'(dd) - NW'(a22) - NW'(a33);
    xy_raw  = (XYW+1)'(xx3) + (XYW+1)'(yy3) - (XYW+1)'(dd);
  end

  always_ff @(posedge clk) begin
    it4.xs   <= it3.xs;
    it4.ys   <= it3.ys;
    it4.zs   <= it3.zs;
    it4.cur  <= it3.cur;
    it4.oor  <= it3.oor;
    it4.held <= (it3.xs == '0) && (it3.ys == '0);
    num4     <= num_sum;
    xyv4     <= xy_raw[XYW] ? '0 : xy_raw[XYW-1:0];
  end

  // --------------------------------------------------------------------------
  // r = floor(sqrt(max(0, x^2+y^2-d^2) * 2^16))
  // --------------------------------------------------------------------------
  rtag_t         rt_in, rt_out;
  logic          vr;
  logic [RW-1:0] r_root;

  assign rt_in.num = $signed(num4);
  assign rt_in.it  = it4;

  aik_root #(
    .IN_W  (VRW),
    .TAG_W ($bits(rtag_t))
  ) u_root_r (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .v_in      ({xyv4, 16'b0}),
    .tag_in    (rt_in),
    .out_valid (vr),
    .root      (r_root),
    .tag_out   (rt_out)
  );

  // --------------------------------------------------------------------------
  // D = num / (2 a2 a3) in Q30, clamped, one quotient bit per stage
  // --------------------------------------------------------------------------
  div_t          div_s [0:QB];
  logic          div_v [0:QB];
  logic [NW-1:0] mag0;
  logic          neg0, den0, ge0;

  always_comb begin
    neg0 = rt_out.num[NW-1];
    mag0 = neg0 ? NW'(-rt_out.num) : rt_out.num;
    den0 = den == '0;
    ge0  = mag0 >= NW'(den);
  end

  always_ff @(posedge clk) begin
    div_s[0].rem     <= mag0[DENW-1:0];
    div_s[0].q       <= '0;
    div_s[0].neg     <= neg0;
    div_s[0].special <= den0 || ge0;
    if (den0) begin
      div_s[0].spv <= neg0 ? -ONE_Q30 : ((rt_out.num == '0) ? '0 : ONE_Q30);
    end else begin
      div_s[0].spv <= neg0 ? -ONE_Q30 : ONE_Q30;
    end
    div_s[0].r  <= r_root;
    div_s[0].it <= rt_out.it;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QB; k++) div_v[k] <= 1'b0;
    end else begin
      div_v[0] <= vr;
      for (int k = 1; k <= QB; k++) div_v[k] <= div_v[k-1];
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [DENW:0] dbl;
    logic          fits;

    always_comb begin
      dbl  = {div_s[k].rem, 1'b0};
      fits = dbl >= {1'b0, den};
    end

    always_ff @(posedge clk) begin
      div_s[k+1].neg     <= div_s[k].neg;
      div_s[k+1].special <= div_s[k].special;
      div_s[k+1].spv     <= div_s[k].spv;
      div_s[k+1].r       <= div_s[k].r;
      div_s[k+1].it      <= div_s[k].it;
      div_s[k+1].q       <= {div_s[k].q[QB-2:0], fits};
      div_s[k+1].rem     <= fits ? DENW'(dbl - {1'b0, den}) : dbl[DENW-1:0];
    end
  end

  // Signed quotient, then 1 - D^2 for the sine root
  logic  vdq, vsq;
  stag_t sdq, ssq;
  logic [30:0] adq;
  logic [61:0] dq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vdq <= 1'b0;
      vsq <= 1'b0;
    end else begin
      vdq <= div_v[QB];
      vsq <= vdq;
    end
  end

  always_ff @(posedge clk) begin
    sdq.r  <= div_s[QB].r;
    sdq.it <= div_s[QB].it;
    if (div_s[QB].special) begin
      sdq.dq <= div_s[QB].spv;
    end else if (div_s[QB].neg) begin
      sdq.dq <= -$signed({2'b0, div_s[QB].q});
    end else begin
      sdq.dq <= $signed({2'b0, div_s[QB].q});
    end
  end

  assign adq = sdq.dq[31] ? 31'(-sdq.dq) : sdq.dq[30:0];

  always_ff @(posedge clk) begin
    ssq <= sdq;
    dq2 <= {31'b0, adq} * {31'b0, adq};
  end

  logic [61:0] sv_full;
  assign sv_full = (62'd1 << 60) - dq2;

  logic           vs;
  logic [SRW-1:0] s_root;
  stag_t          st_out;

  aik_root #(
    .IN_W  (SVW),
    .TAG_W ($bits(stag_t))
  ) u_root_s (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vsq),
    .v_in      (sv_full[SVW-1:0]),
    .tag_in    (ssq),
    .out_valid (vs),
    .root      (s_root),
    .tag_out   (st_out)
  );

  // --------------------------------------------------------------------------
  // M1/M2: a3 sin, a2 + a3 cos, and the CORDIC operands
  // --------------------------------------------------------------------------
  logic               vm1, vm2;
  logic [44:0]        pa;
  logic signed [46:0] pb;
  logic [SRW-1:0]     s1;
  stag_t              sm1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1 <= 1'b0;
      vm2 <= 1'b0;
    end else begin
      vm1 <= vs;
      vm2 <= vm1;
    end
  end

  always_ff @(posedge clk) begin
    pa  <= {31'b0, forearm_length} * {14'b0, s_root};
    pb  <= $signed({33'b0, forearm_length}) * $signed({{15{st_out.dq[31]}}, st_out.dq});
    s1  <= s_root;
    sm1 <= st_out;
  end

  logic signed [NORM_W-1:0] aty [0:4];
  logic signed [NORM_W-1:0] atx [0:4];
  ctag_t                    ct2;

  always_ff @(posedge clk) begin
    // elbow: atan2(-s, D)
    aty[0] <= -$signed({{(NORM_W-SRW){1'b0}}, s1});
    atx[0] <= NORM_W'(sm1.dq);
    // shoulder, first term: atan2(z*256, r)
    aty[1] <= NORM_W'(sm1.it.zs) <<< 8;
    atx[1] <= $signed({{(NORM_W-RW){1'b0}}, sm1.r});
    // shoulder, second term: atan2(-a3 s, a2 + a3 D)
    aty[2] <= -$signed({{(NORM_W-45){1'b0}}, pa});
    atx[2] <= $signed({{(NORM_W-44){1'b0}}, upper_arm_length, 30'b0}) + NORM_W'(pb);
    // pan: atan2(y, x) and atan2(-r, d*256)
    aty[3] <= NORM_W'(sm1.it.ys);
    atx[3] <= NORM_W'(sm1.it.xs);
    aty[4] <= -$signed({{(NORM_W-RW){1'b0}}, sm1.r});
    atx[4] <= NORM_W'(shoulder_offset) <<< 8;
    ct2.cur  <= sm1.it.cur;
    ct2.oor  <= sm1.it.oor;
    ct2.held <= sm1.it.held;
  end

  // --------------------------------------------------------------------------
  // Five atan2 units in lockstep; the first carries the item tag
  // --------------------------------------------------------------------------
  logic signed [ANG_W-1:0] ang [0:4];
  logic                    va;
  ctag_t                   cta;

  aik_atan2 #(
    .TAG_W ($bits(ctag_t))
  ) u_atan_elbow (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vm2),
    .y_in      (aty[0]),
    .x_in      (atx[0]),
    .zneg      (1'b1),
    .tag_in    (ct2),
    .out_valid (va),
    .angle     (ang[0]),
    .tag_out   (cta)
  );

  for (genvar j = 1; j < 5; j++) begin : g_atan
    aik_atan2 #(
      .TAG_W (1)
    ) u_atan (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vm2),
      .y_in      (aty[j]),
      .x_in      (atx[j]),
      .zneg      ((j == 2) || (j == 4)),
      .tag_in    (1'b0),
      .out_valid (),
      .angle     (ang[j]),
      .tag_out   ()
    );
  end

  // --------------------------------------------------------------------------
  // C1..C5: combine, wrap pan, round half away from zero, drive result
  // --------------------------------------------------------------------------
  logic vc1, vc2, vc3, vc4;
  ctag_t ct_c1, ct_c2, ct_c3, ct_c4;
  logic signed [TW-1:0] traw, th2_1, th3_1, tw2;
  logic [TW-1:0]        th2m, th3m, panm, th2r, th3r, panr;
  logic                 th2n2, th3n2, th2n3, th3n3, pann3, pann4;
  logic signed [TW-1:0] th2o, th3o;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc1  <= 1'b0;
      vc2  <= 1'b0;
      vc3  <= 1'b0;
      vc4  <= 1'b0;
      done <= 1'b0;
    end else begin
      vc1  <= va;
      vc2  <= vc1;
      vc3  <= vc2;
      vc4  <= vc3;
      done <= vc4;
    end
  end

  always_ff @(posedge clk) begin
    ct_c1 <= cta;
    traw  <= TW'(ang[3]) + ((shoulder_offset != '0) ? TW'(ang[4]) : '0);
    th2_1 <= TW'(ang[1]) - TW'(ang[2]);
    th3_1 <= TW'(ang[0]);
  end

  always_ff @(posedge clk) begin
    ct_c2 <= ct_c1;
    tw2   <= (traw < -TW'(PI_Q32)) ? traw + (TW'(PI_Q32) <<< 1) : traw;
    th2n2 <= th2_1[TW-1];
    th3n2 <= th3_1[TW-1];
    th2m  <= th2_1[TW-1] ? -th2_1 : th2_1;
    th3m  <= th3_1[TW-1] ? -th3_1 : th3_1;
  end

  always_ff @(posedge clk) begin
    ct_c3 <= ct_c2;
    pann3 <= tw2[TW-1];
    panm  <= tw2[TW-1] ? -tw2 : tw2;
    th2n3 <= th2n2;
    th3n3 <= th3n2;
    th2r  <= (th2m + HALF) >> SH;
    th3r  <= (th3m + HALF) >> SH;
  end

  always_ff @(posedge clk) begin
    ct_c4 <= ct_c3;
    pann4 <= pann3;
    panr  <= (panm + HALF) >> SH;
    th2o  <= th2n3 ? -$signed(th2r) : $signed(th2r);
    th3o  <= th3n3 ? -$signed(th3r) : $signed(th3r);
  end

  // Output register: hold the result for the strobe cycle
  always_ff @(posedge clk) begin
    if (ct_c4.held) begin
      pan_angle <= ct_c4.cur;
    end else begin
      pan_angle <= pann4 ? 18'(-panr) : panr[17:0];
    end
    shoulder_angle <= th2o[18:0];
    elbow_angle    <= th3o[17:0];
    out_of_reach   <= ct_c4.oor;
    pan_held       <= ct_c4.held;
  end

endmodule
`default_nettype wire

// ===== sv/aik_root.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aik_root: pipelined integer square root
// One result bit per stage, floor(sqrt(v)); a tag travels with each item.
// ----------------------------------------------------------------------------
module aik_root import aik_pkg::*; #(
  parameter int IN_W  = 48,
  parameter int TAG_W = 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [IN_W-1:0]           v_in,
  input  wire logic [TAG_W-1:0]          tag_in,
  output logic                           out_valid,
  output logic [(IN_W+1)/2-1:0]          root,
  output logic [TAG_W-1:0]               tag_out
);

  localparam int NS = (IN_W + 1) / 2;

  logic [IN_W-1:0]  rem   [0:NS];
  logic [IN_W:0]    acc   [0:NS];
  logic [TAG_W-1:0] tag   [0:NS];
  logic             vl    [0:NS];

  always_ff @(posedge clk) begin
    rem[0] <= v_in;
    acc[0] <= '0;
    tag[0] <= tag_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NS; k++) vl[k] <= 1'b0;
    end else begin
      vl[0] <= in_valid;
      for (int k = 1; k <= NS; k++) vl[k] <= vl[k-1];
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam logic [IN_W:0] B = (IN_W+1)'(1) << (2 * (NS - 1 - k));
    logic [IN_W:0] trial;
    logic          take;

    always_comb begin
      trial = acc[k] + B;
      take  = {1'b0, rem[k]} >= trial;
    end

    always_ff @(posedge clk) begin
      tag[k+1] <= tag[k];
      if (take) begin
        rem[k+1] <= rem[k] - trial[IN_W-1:0];
        acc[k+1] <= (acc[k] >> 1) + B;
      end else begin
        rem[k+1] <= rem[k];
        acc[k+1] <= acc[k] >> 1;
      end
    end
  end

  assign out_valid = vl[NS];
  assign root      = acc[NS][NS-1:0];
  assign tag_out   = tag[NS];

endmodule
`default_nettype wire

// ===== sv/aik_atan2.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aik_atan2: pipelined atan2 by vectoring CORDIC
// Normalize the larger magnitude into [2^40, 2^41), run 32 rotations,
// then fold in the quadrant. Angle in radians * 2^32.
// ----------------------------------------------------------------------------
module aik_atan2 import aik_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic signed [NORM_W-1:0]   y_in,
  input  wire logic signed [NORM_W-1:0]   x_in,
  input  wire logic                       zneg,
  input  wire logic [TAG_W-1:0]           tag_in,
  output logic                            out_valid,
  output logic signed [ANG_W-1:0]         angle,
  output logic [TAG_W-1:0]                tag_out
);

  localparam int NST = NORM_STEPS + CORDIC_STEPS + 2;

  typedef struct packed {
    logic             zero;
    logic             xneg;
    logic             yneg;
    logic [TAG_W-1:0] tag;
  } flag_t;

  logic signed [NORM_W-1:0]   nx [0:NORM_STEPS];
  logic signed [NORM_W-1:0]   ny [0:NORM_STEPS];
  logic [NORM_W-1:0]          nm [0:NORM_STEPS];
  logic signed [CORDIC_W-1:0] cx [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] cy [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0]    cz [0:CORDIC_STEPS];
  flag_t                      fl [0:NST-1];
  logic                       vl [0:NST-1];

  logic signed [NORM_W-1:0] ax, ay;

  always_comb begin
    ax = x_in[NORM_W-1] ? -x_in : x_in;
    ay = y_in[NORM_W-1] ? -y_in : y_in;
  end

  // Prep: fold x into the right half plane, note signs
  always_ff @(posedge clk) begin
    nx[0]      <= ax;
    ny[0]      <= y_in;
    nm[0]      <= (ax > ay) ? ax : ay;
    fl[0].zero <= (x_in == '0) && (y_in == '0);
    fl[0].xneg <= x_in[NORM_W-1];
    fl[0].yneg <= y_in[NORM_W-1] || ((y_in == '0) && zneg);
    fl[0].tag  <= tag_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) vl[k] <= 1'b0;
    end else begin
      vl[0] <= in_valid;
      for (int k = 1; k < NST; k++) vl[k] <= vl[k-1];
    end
  end

  // Normalize by binary search on the shift amount
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int K = 32 >> j;
    logic big, little;

    always_comb begin
      little = nm[j] < (NORM_W'(1) << (41 - K));
    end
    if (40 + K < NORM_W - 1) begin : g_big
      always_comb big = nm[j] >= (NORM_W'(1) << (40 + K));
    end else begin : g_nobig
      always_comb big = 1'b0;
    end

    always_ff @(posedge clk) begin
      fl[j+1] <= fl[j];
      if (big) begin
        nx[j+1] <= nx[j] >>> K;
        ny[j+1] <= ny[j] >>> K;
        nm[j+1] <= nm[j] >> K;
      end else if (little) begin
        nx[j+1] <= nx[j] <<< K;
        ny[j+1] <= ny[j] <<< K;
        nm[j+1] <= nm[j] << K;
      end else begin
        nx[j+1] <= nx[j];
        ny[j+1] <= ny[j];
        nm[j+1] <= nm[j];
      end
    end
  end

  assign cx[0] = nx[NORM_STEPS][CORDIC_W-1:0];
  assign cy[0] = ny[NORM_STEPS][CORDIC_W-1:0];
  assign cz[0] = '0;

  // Rotate toward the x axis, one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam logic signed [ANG_W-1:0] STEP_ANG = $signed({4'b0, ATAN_TAB[i]});
    logic signed [CORDIC_W-1:0] dx, dy;

    always_comb begin
      dx = cy[i] >>> i;
      dy = cx[i] >>> i;
    end

    always_ff @(posedge clk) begin
      fl[NORM_STEPS+1+i] <= fl[NORM_STEPS+i];
      if (!cy[i][CORDIC_W-1]) begin
        cx[i+1] <= cx[i] + dx;
        cy[i+1] <= cy[i] - dy;
        cz[i+1] <= cz[i] + STEP_ANG;
      end else begin
        cx[i+1] <= cx[i] - dx;
        cy[i+1] <= cy[i] + dy;
        cz[i+1] <= cz[i] - STEP_ANG;
      end
    end
  end

  // Quadrant fold; both operands zero give zero
  always_ff @(posedge clk) begin
    fl[NST-1] <= fl[NST-2];
    if (fl[NST-2].zero) begin
      angle <= '0;
    end else if (fl[NST-2].xneg) begin
      angle <= (fl[NST-2].yneg ? -PI_Q32 : PI_Q32) - cz[CORDIC_STEPS];
    end else begin
      angle <= cz[CORDIC_STEPS];
    end
  end

  assign out_valid = vl[NST-1];
  assign tag_out   = fl[NST-1].tag;

endmodule
`default_nettype wire
